### rtl/ucd_pkg.sv
`default_nettype none

package ucd_pkg;

    localparam int unsigned MAX_BLOCK_BYTES_DEF = 256;

    // bytes of a descriptor after its length byte that the scan looks at
    localparam int unsigned WIN_LEN = 7;

    localparam int unsigned TOTAL_LO_OFS = 2;
    localparam int unsigned TOTAL_HI_OFS = 3;
    localparam int unsigned CONF_VAL_OFS = 5;

    localparam logic [7:0] DESC_INTERFACE = 8'h04;
    localparam logic [7:0] DESC_ENDPOINT  = 8'h05;
    localparam logic [7:0] CLASS_HID      = 8'h03;
    localparam logic [7:0] CLASS_HUB      = 8'h09;
    localparam logic [7:0] PROTO_KEYBOARD = 8'h01;
    localparam logic [7:0] PROTO_MOUSE    = 8'h02;
    localparam logic [1:0] XFER_INTERRUPT = 2'b11;
    localparam int unsigned EP_DIR_BIT    = 7;

    localparam logic [15:0] DEF_MAX_PACKET    = 16'd8;
    localparam logic [7:0]  DEF_POLL_INTERVAL = 8'd10;

    typedef enum logic [1:0] {
        IFACE_NONE  = 2'd0,
        IFACE_KBD   = 2'd1,
        IFACE_MOUSE = 2'd2
    } iface_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        iface_kind_t iface_kind;
        logic        hub;
        logic        kbd_found;
        logic [7:0]  kbd_interface;
        logic [3:0]  kbd_endpoint;
        logic [15:0] kbd_max_packet;
        logic [7:0]  kbd_poll_interval;
        logic        mouse_found;
        logic [7:0]  mouse_iface_num;
        logic [3:0]  mouse_endpoint;
        logic [15:0] mouse_max_packet;
        logic [7:0]  mouse_poll_interval;
    } scan_state_t;

    typedef struct packed {
        logic        hub_detected;
        logic        kbd_found;
        logic [7:0]  kbd_interface;
        logic [3:0]  kbd_endpoint;
        logic [15:0] kbd_max_packet;
        logic [7:0]  kbd_poll_interval;
        logic        mouse_found;
        logic [7:0]  mouse_iface_num;
        logic [3:0]  mouse_endpoint;
        logic [15:0] mouse_max_packet;
        logic [7:0]  mouse_poll_interval;
        logic [7:0]  configuration_value;
    } result_t;

    function automatic scan_state_t scan_init();
        scan_state_t r;
        r = '0;
        r.iface_kind          = IFACE_NONE;
        r.kbd_max_packet      = DEF_MAX_PACKET;
        r.kbd_poll_interval   = DEF_POLL_INTERVAL;
        r.mouse_max_packet    = DEF_MAX_PACKET;
        r.mouse_poll_interval = DEF_POLL_INTERVAL;
        return r;
    endfunction

    // fld[k] is the byte k+1 places after the descriptor's length byte
    function automatic scan_state_t desc_step(
        input scan_state_t                 st,
        input logic [WIN_LEN-1:0][7:0]     fld,
        input logic                        en
    );
        scan_state_t r;
        logic [7:0]  kind;
        logic [7:0]  cls;
        logic [7:0]  proto;
        logic [7:0]  addr;
        logic [7:0]  attr;
        logic        intr_in;
        r       = st;
        kind    = fld[0];
        cls     = fld[4];
        proto   = fld[6];
        addr    = fld[1];
        attr    = fld[2];
        intr_in = (attr[1:0] == XFER_INTERRUPT) && addr[EP_DIR_BIT];
        if (en)
        begin
            if (kind == DESC_INTERFACE)
            begin
                r.iface_kind = IFACE_NONE;
                if (cls == CLASS_HUB)
                begin
                    r.hub = 1'b1;
                end
                else if (cls == CLASS_HID)
                begin
                    if (proto == PROTO_KEYBOARD)
                    begin
                        if (!r.kbd_found)
                        begin
                            r.kbd_found     = 1'b1;
                            r.kbd_interface = fld[1];
                            r.iface_kind    = IFACE_KBD;
                        end
                    end
                    else if (proto == PROTO_MOUSE)
                    begin
                        if (!r.mouse_found)
                        begin
                            r.mouse_found     = 1'b1;
                            r.mouse_iface_num = fld[1];
                            r.iface_kind      = IFACE_MOUSE;
                        end
                    end
                end
            end
            else if (kind == DESC_ENDPOINT)
            begin
                if (intr_in)
                begin
                    if (r.iface_kind == IFACE_KBD && r.kbd_endpoint == 4'd0)
                    begin
                        r.kbd_endpoint      = addr[3:0];
                        r.kbd_max_packet    = {fld[4], fld[3]};
                        r.kbd_poll_interval = fld[5];
                    end
                    else if (r.iface_kind == IFACE_MOUSE && r.mouse_endpoint == 4'd0)
                    begin
                        r.mouse_endpoint      = addr[3:0];
                        r.mouse_max_packet    = {fld[4], fld[3]};
                        r.mouse_poll_interval = fld[5];
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/ucd_ifs.sv
`default_nettype none

interface ucd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ucd_out_if;
    logic        valid;
    logic        ready;
    logic        hub_detected;
    logic        kbd_found;
    logic [7:0]  kbd_interface;
    logic [3:0]  kbd_endpoint;
    logic [15:0] kbd_max_packet;
    logic [7:0]  kbd_poll_interval;
    logic        mouse_found;
    logic [7:0]  mouse_iface_num;
    logic [3:0]  mouse_endpoint;
    logic [15:0] mouse_max_packet;
    logic [7:0]  mouse_poll_interval;
    logic [7:0]  configuration_value;

    modport source (
        output valid, input ready,
        output hub_detected, output kbd_found, output kbd_interface, output kbd_endpoint,
        output kbd_max_packet, output kbd_poll_interval, output mouse_found,
        output mouse_iface_num, output mouse_endpoint, output mouse_max_packet,
        output mouse_poll_interval, output configuration_value
    );
    modport sink (
        input valid, output ready,
        input hub_detected, input kbd_found, input kbd_interface, input kbd_endpoint,
        input kbd_max_packet, input kbd_poll_interval, input mouse_found,
        input mouse_iface_num, input mouse_endpoint, input mouse_max_packet,
        input mouse_poll_interval, input configuration_value
    );
endinterface

`default_nettype wire

### rtl/usb_config_descriptor_hid_scanner.sv
// Scans a USB configuration descriptor block one byte per clock as it streams in, following
// the descriptor chain by its length bytes, and on the byte marked last gives one summary
// item: hub detection (from the device class register or a hub interface), the first HID
// boot keyboard and boot mouse interfaces with their first interrupt IN endpoint, and the
// configuration value. Bytes wait in an input register; the summary item is loaded into an
// output register at the edge where the last byte leaves the input register, and it is held
// until taken. The next block's bytes keep flowing meanwhile, and only a last byte waits
// while an earlier summary is still untaken. Sustained rate is one byte per clock. Bytes past
// MAX_BLOCK_BYTES are dropped and fields that were never received read as zero. The device
// class register is written through cfg_wr_en / cfg_wr_data; the user must write it only
// between blocks, and the block itself does not enforce this.
`default_nettype none

module usb_config_descriptor_hid_scanner #(
    parameter int unsigned MAX_BLOCK_BYTES = ucd_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    ucd_in_if.sink          byte_ch,
    ucd_out_if.source       result_ch
);

    ucd_pkg::in_item_t item;
    logic              item_valid;
    logic              take;

    ucd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    ucd_scan_core #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_scan_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .item_valid  (item_valid),
        .take        (take),
        .result_ch   (result_ch)
    );

    a_kbd_default: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && !result_ch.kbd_found |->
            result_ch.kbd_endpoint == 4'd0 && result_ch.kbd_interface == 8'd0
            && result_ch.kbd_max_packet == ucd_pkg::DEF_MAX_PACKET
            && result_ch.kbd_poll_interval == ucd_pkg::DEF_POLL_INTERVAL)
        else $error("keyboard fields set without a keyboard interface");

    a_mouse_default: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && !result_ch.mouse_found |->
            result_ch.mouse_endpoint == 4'd0 && result_ch.mouse_iface_num == 8'd0
            && result_ch.mouse_max_packet == ucd_pkg::DEF_MAX_PACKET
            && result_ch.mouse_poll_interval == ucd_pkg::DEF_POLL_INTERVAL)
        else $error("mouse fields set without a mouse interface");

    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item.last_byte && result_ch.valid && !result_ch.ready |-> !take)
        else $error("last item taken while summary item still pending");

endmodule

`default_nettype wire

### rtl/ucd_in_stage.sv
`default_nettype none

module ucd_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    ucd_in_if.sink                 byte_ch,
    input  wire logic              take,
    output ucd_pkg::in_item_t      item,
    output logic                   item_valid
);

    logic              valid_reg;
    logic              valid_next;
    ucd_pkg::in_item_t item_reg;
    logic              load;

    assign byte_ch.ready = !valid_reg || take;
    assign load          = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte <= byte_ch.data_byte;
            item_reg.last_byte <= byte_ch.last_byte;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

### rtl/ucd_scan_core.sv
`default_nettype none

module ucd_scan_core #(
    parameter int unsigned MAX_BLOCK_BYTES = ucd_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [7:0]        cfg_wr_data,
    input  wire ucd_pkg::in_item_t item,
    input  wire logic              item_valid,
    output logic                   take,
    ucd_out_if.source              result_ch
);

    localparam int unsigned OW = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int unsigned NW = $clog2(MAX_BLOCK_BYTES + 256);
    localparam int unsigned CW = ((OW > 16) ? OW : 16) + 1;
    localparam int unsigned WL = ucd_pkg::WIN_LEN;

    logic [OW-1:0]          offset_reg;
    logic [OW-1:0]          offset_next;
    logic [NW-1:0]          next_start_reg;
    logic [NW-1:0]          next_start_next;
    logic                   walk_active_reg;
    logic                   walk_active_next;
    logic [15:0]            total_reg;
    logic [15:0]            total_next;
    logic [7:0]             conf_val_reg;
    logic [7:0]             conf_val_next;
    logic [WL-1:0][7:0]     win_reg;
    logic [WL-1:0][7:0]     win_next;
    logic [WL-1:0]          flag_reg;
    logic [WL-1:0]          flag_next;
    ucd_pkg::scan_state_t   st_reg;
    ucd_pkg::scan_state_t   st_next;
    logic [7:0]             dev_class_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    ucd_pkg::result_t       res_reg;
    ucd_pkg::result_t       res_next;

    logic                   stored;
    logic [7:0]             cur;
    logic                   start_hit;
    logic                   cur_start;
    logic [15:0]            total_eff;
    logic [CW-1:0]          ofs_ext;
    logic [CW-1:0]          tot_ext;
    logic [7:0]             ext_byte [0:2*WL];
    logic [WL:0]            slot_start;
    logic [WL:0]            slot_en;
    logic [WL-1:0][7:0]     slot_fld [0:WL];
    ucd_pkg::scan_state_t   chain [0:WL+1];

    assign stored    = offset_reg < OW'(MAX_BLOCK_BYTES);
    assign cur       = stored ? item.data_byte : 8'd0;
    assign start_hit = stored && walk_active_reg && (offset_reg != '0)
                       && (NW'(offset_reg) == next_start_reg);
    assign cur_start = start_hit && (cur != 8'd0);

    assign total_eff[7:0]  = (offset_reg == OW'(ucd_pkg::TOTAL_LO_OFS)) ? cur : total_reg[7:0];
    assign total_eff[15:8] = (offset_reg == OW'(ucd_pkg::TOTAL_HI_OFS)) ? cur : total_reg[15:8];
    assign ofs_ext = CW'(offset_reg);
    assign tot_ext = CW'(total_eff);

    // byte window: oldest at 0, current byte at WL, nothing received beyond
    for (genvar i = 0; i <= 2 * WL; i++)
    begin : g_ext
        if (i < WL)
        begin : g_win
            assign ext_byte[i] = win_reg[i];
        end
        else if (i == WL)
        begin : g_cur
            assign ext_byte[i] = cur;
        end
        else
        begin : g_zero
            assign ext_byte[i] = 8'd0;
        end
    end

    assign slot_start = {cur_start, flag_reg};
    assign chain[0]   = st_reg;

    for (genvar j = 0; j <= WL; j++)
    begin : g_slot
        for (genvar k = 0; k < WL; k++)
        begin : g_fld
            assign slot_fld[j][k] = ext_byte[j + 1 + k];
        end
        // descriptor start lies at offset - WL + j, must be below the total length
        assign slot_en[j]  = slot_start[j] && ((ofs_ext + CW'(j)) < (tot_ext + CW'(WL)));
        assign chain[j+1]  = ucd_pkg::desc_step(chain[j], slot_fld[j], slot_en[j]);
    end

    assign take = item_valid && (!item.last_byte || !out_valid_reg || result_ch.ready);

    always_comb
    begin
        offset_next      = offset_reg;
        next_start_next  = next_start_reg;
        walk_active_next = walk_active_reg;
        total_next       = total_reg;
        conf_val_next    = conf_val_reg;
        win_next         = win_reg;
        flag_next        = flag_reg;
        st_next          = st_reg;
        out_valid_next   = out_valid_reg && !result_ch.ready;
        res_next         = res_reg;
        if (take)
        begin
            if (item.last_byte)
            begin
                res_next.hub_detected        = chain[WL+1].hub
                                               || (dev_class_reg == ucd_pkg::CLASS_HUB);
                res_next.kbd_found           = chain[WL+1].kbd_found;
                res_next.kbd_interface       = chain[WL+1].kbd_interface;
                res_next.kbd_endpoint        = chain[WL+1].kbd_endpoint;
                res_next.kbd_max_packet      = chain[WL+1].kbd_max_packet;
                res_next.kbd_poll_interval   = chain[WL+1].kbd_poll_interval;
                res_next.mouse_found         = chain[WL+1].mouse_found;
                res_next.mouse_iface_num     = chain[WL+1].mouse_iface_num;
                res_next.mouse_endpoint      = chain[WL+1].mouse_endpoint;
                res_next.mouse_max_packet    = chain[WL+1].mouse_max_packet;
                res_next.mouse_poll_interval = chain[WL+1].mouse_poll_interval;
                res_next.configuration_value =
                    (offset_reg == OW'(ucd_pkg::CONF_VAL_OFS)) ? cur : conf_val_reg;
                out_valid_next   = 1'b1;
                offset_next      = '0;
                next_start_next  = '0;
                walk_active_next = 1'b0;
                total_next       = 16'd0;
                conf_val_next    = 8'd0;
                flag_next        = '0;
                st_next          = ucd_pkg::scan_init();
            end
            else if (stored)
            begin
                offset_next            = offset_reg + OW'(1);
                total_next             = total_eff;
                win_next[WL-2:0]       = win_reg[WL-1:1];
                win_next[WL-1]         = cur;
                flag_next[WL-2:0]      = flag_reg[WL-1:1];
                flag_next[WL-1]        = cur_start;
                st_next                = chain[1];
                if (offset_reg == OW'(ucd_pkg::CONF_VAL_OFS))
                begin
                    conf_val_next = cur;
                end
                // header length gives the first descriptor start
                if (offset_reg == '0)
                begin
                    next_start_next  = NW'(cur);
                    walk_active_next = (cur != 8'd0);
                end
                else if (start_hit)
                begin
                    if (cur == 8'd0)
                    begin
                        walk_active_next = 1'b0;
                    end
                    else
                    begin
                        next_start_next = NW'(offset_reg) + NW'(cur);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= '0;
            next_start_reg  <= '0;
            walk_active_reg <= 1'b0;
            total_reg       <= 16'd0;
            conf_val_reg    <= 8'd0;
            flag_reg        <= '0;
            st_reg          <= ucd_pkg::scan_init();
            dev_class_reg   <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            offset_reg      <= offset_next;
            next_start_reg  <= next_start_next;
            walk_active_reg <= walk_active_next;
            total_reg       <= total_next;
            conf_val_reg    <= conf_val_next;
            flag_reg        <= flag_next;
            st_reg          <= st_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                dev_class_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        res_reg <= res_next;
    end

    assign result_ch.valid               = out_valid_reg;
    assign result_ch.hub_detected        = res_reg.hub_detected;
    assign result_ch.kbd_found           = res_reg.kbd_found;
    assign result_ch.kbd_interface       = res_reg.kbd_interface;
    assign result_ch.kbd_endpoint        = res_reg.kbd_endpoint;
    assign result_ch.kbd_max_packet      = res_reg.kbd_max_packet;
    assign result_ch.kbd_poll_interval   = res_reg.kbd_poll_interval;
    assign result_ch.mouse_found         = res_reg.mouse_found;
    assign result_ch.mouse_iface_num     = res_reg.mouse_iface_num;
    assign result_ch.mouse_endpoint      = res_reg.mouse_endpoint;
    assign result_ch.mouse_max_packet    = res_reg.mouse_max_packet;
    assign result_ch.mouse_poll_interval = res_reg.mouse_poll_interval;
    assign result_ch.configuration_value = res_reg.configuration_value;

endmodule

`default_nettype wire
